// File: rtl/lpfd_pkg.sv
// Package for the length-prefixed frame deframer.
// Holds the header constants, the result kind codes and the result struct.
// No dependencies.
`default_nettype none

package lpfd_pkg;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned CntW        = $clog2(HeaderBytes);

  localparam logic [31:0] MagicNormal  = 32'h4B27_7B06;
  localparam logic [31:0] MagicSwapped = 32'h067B_274B;
  localparam logic [31:0] MaxLenReset  = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_BAD_TYPE  = 2'd1,
    KIND_ZERO_LEN  = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'b01,
    MODE_PAYLOAD = 2'b10
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic        swapped_order;
  } lpfd_result_t;

endpackage

`default_nettype wire

// File: rtl/lpfd_in_stage.sv
// Input register of the deframer: holds one received byte until the
// decode stage takes it. Depends on nothing but the clock and reset.
`default_nettype none

module lpfd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            item_valid_o,
  output logic [7:0]      item_byte_o,
  input  wire logic       item_take_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The register may be refilled in the same cycle that the decode stage empties it.
  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

`default_nettype wire

// File: rtl/lpfd_decode.sv
// Decode stage of the deframer: header collection, header checks, payload
// counting and the result register. Depends on lpfd_pkg.
`default_nettype none

module lpfd_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  input  wire logic [7:0]          item_byte_i,
  output logic                     item_take_o,
  input  wire logic [31:0]         max_len_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lpfd_pkg::lpfd_result_t   result_o
);

  localparam int unsigned CntW = lpfd_pkg::CntW;
  localparam logic [CntW-1:0] CntLast = CntW'(lpfd_pkg::HeaderBytes - 1);

  lpfd_pkg::mode_e        mode_q, mode_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [31:0]            rem_q, rem_d;
  logic                   swap_q, swap_d;
  logic [7:0]             hdr_q [0:lpfd_pkg::HeaderBytes-2];
  logic                   hdr_we;

  logic                   out_valid_q, out_valid_d;
  lpfd_pkg::lpfd_result_t res_q, res_d;
  logic                   res_valid;

  logic [31:0]            type_w, len_le, len_sw, len_sel;
  logic                   is_normal, is_swapped, pay_last;

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);

  // The eighth header byte is used straight from the input register.
  assign type_w     = {item_byte_i, hdr_q[6], hdr_q[5], hdr_q[4]};
  assign len_le     = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
  assign len_sw     = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
  assign is_normal  = (type_w == lpfd_pkg::MagicNormal);
  assign is_swapped = (type_w == lpfd_pkg::MagicSwapped);
  assign len_sel    = is_swapped ? len_sw : len_le;
  assign pay_last   = (rem_q <= 32'd1);

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    swap_d    = swap_q;
    hdr_we    = 1'b0;
    res_valid = 1'b0;
    res_d     = '{kind: lpfd_pkg::KIND_PAYLOAD, payload_byte: 8'd0,
                  last: 1'b0, swapped_order: 1'b0};
    if (item_take_o) begin
      case (mode_q)
        lpfd_pkg::MODE_PAYLOAD: begin
          res_valid           = 1'b1;
          res_d.payload_byte  = item_byte_i;
          res_d.last          = pay_last;
          res_d.swapped_order = swap_q;
          if (pay_last) begin
            mode_d = lpfd_pkg::MODE_HUNT;
            rem_d  = 32'd0;
          end else begin
            rem_d = rem_q - 32'd1;
          end
        end
        lpfd_pkg::MODE_HUNT: begin
          if (cnt_q != CntLast) begin
            hdr_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
          end else begin
            cnt_d = '0;
            if (!is_normal && !is_swapped) begin
              res_valid  = 1'b1;
              res_d.kind = lpfd_pkg::KIND_BAD_TYPE;
            end else if (len_sel == 32'd0) begin
              res_valid           = 1'b1;
              res_d.kind          = lpfd_pkg::KIND_ZERO_LEN;
              res_d.swapped_order = is_swapped;
            end else if (len_sel > max_len_i) begin
              res_valid           = 1'b1;
              res_d.kind          = lpfd_pkg::KIND_TOO_LARGE;
              res_d.swapped_order = is_swapped;
            end else begin
              mode_d = lpfd_pkg::MODE_PAYLOAD;
              rem_d  = len_sel;
              swap_d = is_swapped;
            end
          end
        end
        default: begin
          mode_d = lpfd_pkg::MODE_HUNT;
          cnt_d  = '0;
          rem_d  = 32'd0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= lpfd_pkg::MODE_HUNT;
      cnt_q       <= '0;
      rem_q       <= 32'd0;
      swap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      swap_q      <= swap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[cnt_q] <= item_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

`ifndef SYNTH
  a_payload_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == lpfd_pkg::MODE_PAYLOAD |-> rem_q != 32'd0)
    else $error("payload mode with no bytes remaining");

  a_hunt_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == lpfd_pkg::MODE_HUNT |-> rem_q == 32'd0)
    else $error("remaining count not cleared while hunting");

  a_payload_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == lpfd_pkg::MODE_PAYLOAD |-> cnt_q == '0)
    else $error("header count left over in payload mode");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && mode_q == lpfd_pkg::MODE_PAYLOAD && pay_last
    |=> mode_q == lpfd_pkg::MODE_HUNT)
    else $error("frame did not end after its last byte");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind != lpfd_pkg::KIND_PAYLOAD
    |-> !res_q.last && res_q.payload_byte == 8'd0)
    else $error("error result carries payload fields");
`endif

endmodule

`default_nettype wire

// File: rtl/length_prefixed_frame_deframer_core.sv
// Each accepted byte passes the input register, then the result register, to the output.
// Throughput: one byte per cycle, set by the input register, unless the output stalls.
// Header bytes and good headers give no result; each payload byte and each error one.
// Reset (rst_ni low, asynchronous) empties both registers, restarts header hunting
// and sets the maximum payload length to 1048576.
`default_nettype none

module length_prefixed_frame_deframer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel: the maximum payload length.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  // Received byte stream.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  // Results.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_o,
  output logic             swapped_order_o
);

  logic                   item_valid;
  logic [7:0]             item_byte;
  logic                   item_take;
  logic [31:0]            max_len_q;
  lpfd_pkg::lpfd_result_t result;

  // The configuration register is always ready; a transaction is to be issued only
  // while idle, so it never changes under a frame. The block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpfd_pkg::MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Input register: parts the upstream handshake from the decode logic,
  // and refills in the same cycle in which the decode stage takes its byte.
  lpfd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte),
    .item_take_i  (item_take)
  );

  // Decode stage: collects the eight header bytes, checks the type word in
  // both byte orders, checks the length against zero and the maximum, then
  // counts the payload through. Its result register is the output register,
  // so a stalled result holds while the next byte waits in the input register.
  lpfd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_byte_i  (item_byte),
    .item_take_o  (item_take),
    .max_len_i    (max_len_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign kind_o          = result.kind;
  assign payload_byte_o  = result.payload_byte;
  assign last_o          = result.last;
  assign swapped_order_o = result.swapped_order;

endmodule

`default_nettype wire

// File: tb/length_prefixed_frame_deframer_core_tb.sv
// Self-checking testbench for length_prefixed_frame_deframer_core.
// Predicts every result from the byte stream and the maximum length register;
// needs lpfd_pkg and the core itself, nothing else.
module length_prefixed_frame_deframer_core_tb;

  // Plan of the run: the maximum length used in each phase. The first phase
  // runs with the reset value, and the entry for phase five is replaced by a
  // random small limit when it is written.
  localparam int unsigned PhaseCount    = 7;
  localparam int unsigned ItemsPerPhase = 190;
  localparam int unsigned RxHoldCycles  = 300;
  localparam int unsigned QuietLimit    = 4000;
  localparam logic [31:0] LimitPlan [PhaseCount] = '{
    lpfd_pkg::MaxLenReset, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd16, 32'd0,
    lpfd_pkg::MaxLenReset
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;
  logic        swapped_order_o;

  length_prefixed_frame_deframer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o),
    .swapped_order_o(swapped_order_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deframer state as the testbench sees it. It mirrors the behaviour of the
  // block: an 8-byte header is gathered, checked and then either rejected with
  // one error result or followed by its payload, one result per byte.
  // ---------------------------------------------------------------------------
  logic [31:0] max_len       = lpfd_pkg::MaxLenReset;
  logic        in_frame      = 1'b0;
  logic [2:0]  hdr_cnt       = '0;
  logic [63:0] hdr_bytes     = '0;
  logic [31:0] bytes_left    = '0;
  logic        frame_swapped = 1'b0;

  logic [7:0]             rx_stream_q [$];   // bytes still to be offered to the block
  lpfd_pkg::lpfd_result_t deframed_q  [$];   // results the block owes us, oldest first
  int unsigned            items_queued = 0;
  int unsigned            fault_count  = 0;
  int unsigned            quiet_cycles = 0;

  // Handshake outcomes of the latest rising edge, read by the falling-edge
  // processes to decide what to drive next.
  bit in_fire_seen  = 1'b0;
  bit out_fire_seen = 1'b0;

  bit          tx_steady     = 1'b0;
  int unsigned tx_gap_left   = 0;
  bit          rx_steady     = 1'b0;
  bit          rx_hold_req   = 1'b0;
  int unsigned rx_hold_left  = 0;
  int unsigned rx_stall_left = 0;

  function automatic logic [31:0] byte_swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Advances the deframer by one byte. Returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b,
                                      output lpfd_pkg::lpfd_result_t res);
    logic [31:0] len;
    logic [31:0] type_word;
    logic        sw;
    res = '0;
    if (in_frame) begin
      res.kind          = lpfd_pkg::KIND_PAYLOAD;
      res.payload_byte  = b;
      res.last          = (bytes_left <= 32'd1);
      res.swapped_order = frame_swapped;
      if (bytes_left <= 32'd1) begin
        bytes_left = '0;
        in_frame   = 1'b0;
        hdr_cnt    = '0;
        hdr_bytes  = '0;
      end else begin
        bytes_left = bytes_left - 32'd1;
      end
      return 1'b1;
    end

    hdr_bytes = hdr_bytes | (64'(b) << {hdr_cnt, 3'b000});
    if (hdr_cnt != 3'd7) begin
      hdr_cnt = hdr_cnt + 3'd1;
      return 1'b0;
    end

    // Eighth byte: the header is complete, so the header count restarts whatever it says.
    len       = hdr_bytes[31:0];
    type_word = hdr_bytes[63:32];
    hdr_cnt   = '0;
    hdr_bytes = '0;
    in_frame  = 1'b0;
    if (type_word == lpfd_pkg::MagicNormal) begin
      sw = 1'b0;
    end else if (type_word == lpfd_pkg::MagicSwapped) begin
      sw  = 1'b1;
      len = byte_swap32(len);
    end else begin
      res.kind = lpfd_pkg::KIND_BAD_TYPE;
      return 1'b1;
    end
    if (len == '0) begin
      res.kind          = lpfd_pkg::KIND_ZERO_LEN;
      res.swapped_order = sw;
      return 1'b1;
    end
    if (len > max_len) begin
      res.kind          = lpfd_pkg::KIND_TOO_LARGE;
      res.swapped_order = sw;
      return 1'b1;
    end
    frame_swapped = sw;
    bytes_left    = len;
    in_frame      = 1'b1;
    return 1'b0;
  endfunction

  task automatic note_fault(input bit have_due, input lpfd_pkg::lpfd_result_t due);
    fault_count++;
    if (fault_count <= 10) begin
      if (have_due)
        $display({"%0t: result mismatch: expected kind=%0d byte=%02h last=%0b ",
                  "swapped=%0b, got kind=%0d byte=%02h last=%0b swapped=%0b"},
                 $time, due.kind, due.payload_byte, due.last, due.swapped_order,
                 kind_o, payload_byte_o, last_o, swapped_order_o);
      else
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b swapped=%0b",
                 $time, kind_o, payload_byte_o, last_o, swapped_order_o);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples all three channels at the rising edge. Outgoing results
  // are checked against the oldest expectation before the byte accepted at the
  // same edge is run through the predictor, so the order of the two never
  // matters. The watchdog lives here as well.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lpfd_pkg::lpfd_result_t due;
    in_fire_seen  = rst_ni && in_valid_i && in_ready_o;
    out_fire_seen = rst_ni && out_valid_o && out_ready_i;

    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      max_len = cfg_data_i;
    end

    if (out_fire_seen) begin
      if (deframed_q.size() == 0) begin
        due = '0;
        note_fault(1'b0, due);
      end else begin
        due = deframed_q.pop_front();
        if (kind_o !== due.kind || payload_byte_o !== due.payload_byte ||
            last_o !== due.last || swapped_order_o !== due.swapped_order) begin
          note_fault(1'b1, due);
        end
      end
    end

    if (in_fire_seen && deframe_byte(in_byte_i, due)) begin
      deframed_q.push_back(due);
    end

    if (in_fire_seen || out_fire_seen || (rst_ni && cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver: changes the input channel at the falling edge. Each byte
  // carries a gap, drawn when it is launched, that is served after the byte has
  // been accepted. Now and then the driver switches into a steady mode without
  // gaps so that back-to-back stretches occur as well.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire_seen)) begin
      if (tx_gap_left != 0) begin
        tx_gap_left--;
        in_valid_i <= 1'b0;
        in_byte_i  <= 8'($urandom);
      end else if (rx_stream_q.size() != 0) begin
        if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
        in_valid_i  <= 1'b1;
        in_byte_i   <= rx_stream_q.pop_front();
        tx_gap_left = tx_steady ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: after each transaction it draws a stall before it is
  // ready again. A hold-off request makes it refuse results for a long stretch
  // so that the block backs up and stops taking bytes.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req) begin
        rx_hold_left = RxHoldCycles;
        rx_hold_req  = 1'b0;
      end
      if (out_fire_seen) begin
        if ($urandom_range(0, 29) == 0) rx_steady = ~rx_steady;
        rx_stall_left = rx_steady ? 0 : $urandom_range(0, 17);
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream building blocks.
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    rx_stream_q.push_back(b);
    items_queued++;
  endtask

  // Four bytes, least significant first.
  task automatic queue_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) queue_byte(w[8*i +: 8]);
  endtask

  // A header in either byte order; in swapped order the length goes big-endian.
  task automatic queue_header(input logic [31:0] len, input bit sw,
                              input logic [31:0] type_word);
    queue_word(sw ? byte_swap32(len) : len);
    queue_word(type_word);
  endtask

  // One unit of random stream. Every unit keeps the 8-byte header alignment,
  // so most traffic is well-formed frames with random content, mixed with
  // rejected headers and whole headers of noise.
  task automatic queue_random_unit();
    int unsigned pick;
    int unsigned cap;
    logic [31:0] len;
    logic [31:0] magic;
    bit          sw;
    pick  = $urandom_range(0, 99);
    sw    = $urandom_range(0, 1);
    magic = sw ? lpfd_pkg::MagicSwapped : lpfd_pkg::MagicNormal;
    if (pick < 60 && max_len != '0) begin
      // Mostly short payloads, with an occasional longer one and the limit itself.
      cap = ($urandom_range(0, 9) == 0) ? 48 : 10;
      len = $urandom_range(1, (max_len < cap) ? max_len : cap);
      if (max_len <= 32'd48 && $urandom_range(0, 5) == 0) len = max_len;
      queue_header(len, sw, magic);
      repeat (len) queue_byte(8'($urandom));
    end else if (pick < 72) begin
      queue_header('0, sw, magic);
    end else if (pick < 84 && max_len != 32'hFFFF_FFFF) begin
      case ($urandom_range(0, 3))
        0, 1: len = max_len + 32'd1;
        2:    len = 32'hFFFF_FFFF;
        default: len = $urandom_range(max_len + 32'd1, 32'hFFFF_FFFF);
      endcase
      queue_header(len, sw, magic);
    end else if (pick < 94) begin
      // Either a wholly random type or a magic with a single bit wrong.
      if ($urandom_range(0, 1) == 0) magic = $urandom;
      else magic = magic ^ (32'd1 << $urandom_range(0, 31));
      queue_header($urandom, sw, magic);
    end else begin
      repeat (8) queue_byte(8'($urandom));
    end
  endtask

  // The sender pauses until every owed result has arrived, then leaves room
  // for a header byte still inside the block.
  task automatic wait_drained();
    while (rx_stream_q.size() != 0 || in_valid_i || deframed_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max_len(input logic [31:0] value);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run: reset, a short directed stream, then phases of random
  // traffic, each under its own maximum length, written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int unsigned phase_end;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PhaseCount; p++) begin
      if (p != 0) begin
        wait_drained();
        write_max_len(p == 5 ? 32'($urandom_range(2, 60)) : LimitPlan[p]);
      end
      @(posedge clk_i);

      if (p == 0) begin
        // A normal-order frame carrying the two extreme byte values, a
        // swapped-order header with zero length, and a type one bit off the
        // magic.
        queue_header(32'd2, 1'b0, lpfd_pkg::MagicNormal);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_header('0, 1'b1, lpfd_pkg::MagicSwapped);
        queue_header(32'h0102_0304, 1'b0, lpfd_pkg::MagicNormal ^ 32'd1);
      end else if (p == 1) begin
        // At the smallest limit: the limit itself in swapped order, then the
        // largest possible length.
        queue_header(32'd1, 1'b1, lpfd_pkg::MagicSwapped);
        queue_byte(8'hA5);
        queue_header(32'hFFFF_FFFF, 1'b0, lpfd_pkg::MagicNormal);
      end else if (p == 2) begin
        // Long refusal on the result side while the bytes keep coming.
        rx_hold_req = 1'b1;
      end else if (p == 3) begin
        // A zero maximum turns even a one-byte frame into a too-large error.
        queue_header(32'd1, 1'b0, lpfd_pkg::MagicNormal);
        queue_header(32'd1, 1'b1, lpfd_pkg::MagicSwapped);
      end

      phase_end = items_queued + ItemsPerPhase;
      while (items_queued < phase_end) queue_random_unit();
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fault_count == 0 && deframed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
